// ===== src/lbp_pkg.sv =====
`timescale 1ns / 1ps
package lbp_pkg;
  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 16;
  localparam int BND_W     = 32;
  localparam int RHS_W     = 48;
  localparam int K_W       = COEF_W + 1;
  localparam int PROD_W    = K_W + BND_W;
  localparam int SUM_W     = 58;
  localparam int DIV_W     = SUM_W;
  localparam int DVS_W     = COEF_W;
  localparam int Q_W       = SUM_W + 2;
  localparam int OIDX_W    = 6;
  localparam int ST_W      = 2;

  localparam logic [ST_W-1:0] ST_UNCH   = 2'd0;
  localparam logic [ST_W-1:0] ST_TIGHT  = 2'd1;
  localparam logic [ST_W-1:0] ST_CONTRA = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO   = 2'd3;

  localparam logic REG_RHS = 1'b0;
  localparam logic REG_EQ  = 1'b1;

  // coefficient in the low bits, as on the input beat
  typedef struct packed {
    logic [BND_W-1:0]  hi;
    logic [BND_W-1:0]  lo;
    logic [COEF_W-1:0] coef;
  } term_t;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [DIV_W-1:0] quo;
  } div_res_t;

  function automatic logic signed [PROD_W-1:0] min_contrib(
    input logic signed [K_W-1:0] k,
    input logic signed [BND_W-1:0] lo,
    input logic signed [BND_W-1:0] hi
  );
    logic signed [BND_W-1:0] x;
    x = k[K_W-1] ? hi : lo;
    return PROD_W'(k * x);
  endfunction
endpackage

// ===== src/linear_bounds_propagator_core.sv =====
`timescale 1ns / 1ps
// Bounds propagator for sum(c*x) <= rhs (and its reverse in equality mode).
// Terms stream in one a cycle into a term RAM; the beat with tlast, or the
// MAX_TERMS-th beat, starts the run. Each term of a sweep goes through a
// read and multiply, the 58-step bit-serial division of the remainder by
// the coefficient, and a check and update; equality mode adds a reload
// pass over the terms and a second sweep. Results then leave from the RAM,
// one beat per term, or a single contradiction / zero-coefficient beat.
// No input is taken until the last result of a run is in the output
// register.
module linear_bounds_propagator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lbp_pkg::RHS_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [79:0]                 in_tdata,  // coefficient, lo bound, hi bound
  input  logic                        in_tlast,  // last term
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [71:0]                 out_tdata, // term_index, new_lower, new_upper
  output logic [lbp_pkg::ST_W-1:0]    out_tuser, // status
  output logic                        out_tlast  // last_result
);
  import lbp_pkg::*;

  localparam logic [4:0] S_LOAD = 5'd0,  S_FIN  = 5'd1,  S_RD   = 5'd2,  S_MUL1 = 5'd3;
  localparam logic [4:0] S_REM  = 5'd4,  S_DST  = 5'd5,  S_DIV  = 5'd6,  S_Q    = 5'd7;
  localparam logic [4:0] S_CHK  = 5'd8,  S_MUL2 = 5'd9,  S_SUM  = 5'd10, S_IRD  = 5'd11;
  localparam logic [4:0] S_IMUL = 5'd12, S_IACC = 5'd13, S_ORD  = 5'd14, S_OSND = 5'd15;
  localparam logic [4:0] S_ONE  = 5'd16;

  logic [4:0]               state_r;
  logic signed [RHS_W-1:0]  rhs_r;
  logic                     eq_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     pend_r;
  logic signed [PROD_W-1:0] lprod_r;
  logic                     zseen_r;
  logic [IDX_W-1:0]         zidx_r;
  logic [IDX_W-1:0]         p_r;
  logic                     sw2_r;
  logic [MAX_TERMS-1:0]     chg_r;
  logic signed [K_W-1:0]    k_r;
  logic signed [BND_W-1:0]  lo_r;
  logic signed [BND_W-1:0]  hi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  wo_r;
  logic signed [SUM_W-1:0]  rr_r;
  logic signed [Q_W-1:0]    q_r;
  logic [IDX_W-1:0]         bidx_r;
  logic [ST_W-1:0]          bst_r;
  logic                     ov_r;
  logic [71:0]              od_r;
  logic [ST_W-1:0]          ou_r;
  logic                     ol_r;

  term_t                    in_term;
  term_t                    rd;
  term_t                    wr;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_wa;
  logic                     ram_re;
  logic                     accept;
  logic                     in_last;
  logic                     p_last;
  logic                     out_free;
  logic signed [K_W-1:0]    k_rd;
  logic signed [SUM_W-1:0]  rhs_eff;
  logic [DIV_W-1:0]         r_mag;
  logic [K_W-1:0]           k_mag;
  logic                     dv_start;
  div_res_t                 dv_res;
  logic signed [Q_W-1:0]    q_tr;
  logic                     q_neg;
  logic                     chk_tight;
  logic                     chk_bad;

  assign in_term  = in_tdata[79:0];
  assign in_tready = (state_r == S_LOAD);
  assign accept   = in_tvalid && in_tready;
  assign in_last  = in_tlast || (cnt_r == CNT_W'(MAX_TERMS - 1));
  assign p_last   = (CNT_W'(p_r) + 1'b1 == cnt_r);
  assign out_free = !ov_r || out_tready;

  assign k_rd    = sw2_r ? -K_W'(signed'(rd.coef)) : K_W'(signed'(rd.coef));
  assign rhs_eff = sw2_r ? -SUM_W'(rhs_r) : SUM_W'(rhs_r);
  assign r_mag   = rr_r[SUM_W-1] ? DIV_W'(-rr_r) : DIV_W'(rr_r);
  assign k_mag   = k_r[K_W-1] ? K_W'(-k_r) : K_W'(k_r);
  assign dv_start = (state_r == S_DST);
  assign q_neg   = rr_r[SUM_W-1] ^ k_r[K_W-1];
  assign q_tr    = q_neg ? -Q_W'(dv_res.quo) : Q_W'(dv_res.quo);

  assign chk_tight = !k_r[K_W-1] ? (hi_r > q_r) : (lo_r < q_r);
  assign chk_bad   = !k_r[K_W-1] ? (q_r < lo_r) : (q_r > hi_r);

  assign ram_we = accept || (state_r == S_CHK);
  assign ram_wa = accept ? cnt_r[IDX_W-1:0] : p_r;
  assign ram_re = (state_r == S_RD) || (state_r == S_IRD) || (state_r == S_ORD);

  always_comb begin
    wr = in_term;
    if (!accept) begin
      wr.coef = sw2_r ? COEF_W'(-k_r) : k_r[COEF_W-1:0];
      wr.lo   = lo_r;
      wr.hi   = hi_r;
      if (chk_tight && !chk_bad) begin
        if (!k_r[K_W-1]) begin
          wr.hi = q_r[BND_W-1:0];
        end else begin
          wr.lo = q_r[BND_W-1:0];
        end
      end
    end
  end

  lbp_term_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (wr),
    .re    (ram_re),
    .raddr (p_r),
    .rdata (rd)
  );

  lbp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .dvd   (r_mag),
    .dvs   (k_mag[DVS_W-1:0]),
    .res   (dv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rhs_r <= '0;
      eq_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RHS: rhs_r <= cfg_wdata;
        REG_EQ:  eq_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      sum_r   <= '0;
      pend_r  <= 1'b0;
      zseen_r <= 1'b0;
      sw2_r   <= 1'b0;
      ov_r    <= 1'b0;
      p_r     <= '0;
    end else begin
      if (ov_r && out_tready && state_r != S_OSND && state_r != S_ONE) begin
        ov_r <= 1'b0;
      end
      pend_r <= accept;
      if (pend_r) begin
        sum_r <= sum_r + SUM_W'(lprod_r);
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            lprod_r <= min_contrib(K_W'(signed'(in_term.coef)), in_term.lo, in_term.hi);
            cnt_r   <= cnt_r + 1'b1;
            if (in_term.coef == '0 && !zseen_r) begin
              zseen_r <= 1'b1;
              zidx_r  <= cnt_r[IDX_W-1:0];
            end
            if (in_last) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          p_r   <= '0;
          sw2_r <= 1'b0;
          chg_r <= '0;
          if (zseen_r) begin
            bidx_r  <= zidx_r;
            bst_r   <= ST_ZERO;
            state_r <= S_ONE;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD:  state_r <= S_MUL1;
        S_MUL1: begin
          k_r     <= k_rd;
          lo_r    <= rd.lo;
          hi_r    <= rd.hi;
          prod_r  <= min_contrib(k_rd, rd.lo, rd.hi);
          state_r <= S_REM;
        end
        S_REM: begin
          wo_r    <= sum_r - SUM_W'(prod_r);
          rr_r    <= rhs_eff - sum_r + SUM_W'(prod_r);
          state_r <= S_DST;
        end
        S_DST: state_r <= S_DIV;
        S_DIV: begin
          if (dv_res.done) begin
            state_r <= S_Q;
          end
        end
        S_Q: begin
          if (!k_r[K_W-1]) begin
            q_r <= (q_neg && dv_res.rem_nz) ? q_tr - 1'b1 : q_tr;
          end else begin
            q_r <= (!q_neg && dv_res.rem_nz) ? q_tr + 1'b1 : q_tr;
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (chk_tight && chk_bad) begin
            bidx_r  <= p_r;
            bst_r   <= ST_CONTRA;
            state_r <= S_ONE;
          end else begin
            state_r <= S_MUL2;
            if (chk_tight) begin
              chg_r[p_r] <= 1'b1;
              if (!k_r[K_W-1]) begin
                hi_r <= q_r[BND_W-1:0];
              end else begin
                lo_r <= q_r[BND_W-1:0];
              end
            end
          end
        end
        S_MUL2: begin
          prod_r  <= min_contrib(k_r, lo_r, hi_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (p_last) begin
            p_r <= '0;
            if (!sw2_r && eq_r) begin
              sum_r   <= '0;
              state_r <= S_IRD;
            end else begin
              sum_r   <= wo_r + SUM_W'(prod_r);
              state_r <= S_ORD;
            end
          end else begin
            sum_r   <= wo_r + SUM_W'(prod_r);
            p_r     <= p_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_IRD: state_r <= S_IMUL;
        S_IMUL: begin
          prod_r  <= min_contrib(-K_W'(signed'(rd.coef)), rd.lo, rd.hi);
          state_r <= S_IACC;
        end
        S_IACC: begin
          sum_r <= sum_r + SUM_W'(prod_r);
          if (p_last) begin
            p_r     <= '0;
            sw2_r   <= 1'b1;
            state_r <= S_RD;
          end else begin
            p_r     <= p_r + 1'b1;
            state_r <= S_IRD;
          end
        end
        S_ORD: state_r <= S_OSND;
        S_OSND: begin
          if (out_free) begin
            ov_r <= 1'b1;
            od_r <= {2'b00, rd.hi, rd.lo, OIDX_W'(p_r)};
            ou_r <= chg_r[p_r] ? ST_TIGHT : ST_UNCH;
            ol_r <= p_last;
            if (p_last) begin
              cnt_r   <= '0;
              sum_r   <= '0;
              zseen_r <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              p_r     <= p_r + 1'b1;
              state_r <= S_ORD;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            od_r    <= {2'b00, BND_W'(0), BND_W'(0), OIDX_W'(bidx_r)};
            ou_r    <= bst_r;
            ol_r    <= 1'b1;
            cnt_r   <= '0;
            sum_r   <= '0;
            zseen_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    dv_res.done |-> state_r == S_DIV)
    else $error("divider finished outside the wait state");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (ou_r == ST_CONTRA || ou_r == ST_ZERO)) |-> ol_r)
    else $error("contradiction or zero result not marked last");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TERMS))
    else $error("term count beyond capacity");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n && accept && in_last) |-> !in_tready)
    else $error("input taken after the final term");
endmodule

// ===== src/lbp_term_ram.sv =====
`timescale 1ns / 1ps
module lbp_term_ram (
  input  logic                  clk,
  input  logic                  we,
  input  logic [lbp_pkg::IDX_W-1:0] waddr,
  input  lbp_pkg::term_t        wdata,
  input  logic                  re,
  input  logic [lbp_pkg::IDX_W-1:0] raddr,
  output lbp_pkg::term_t        rdata
);
  import lbp_pkg::*;

  term_t mem [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/lbp_div.sv =====
`timescale 1ns / 1ps
module lbp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lbp_pkg::DIV_W-1:0] dvd,
  input  logic [lbp_pkg::DVS_W-1:0] dvs,
  output lbp_pkg::div_res_t         res
);
  import lbp_pkg::*;

  localparam int ITER_W = $clog2(DIV_W + 1);

  logic [ITER_W-1:0] iter_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(DIV_W);
        rem_r  <= '0;
        quo_r  <= dvd;
        dvs_r  <= dvs;
      end else if (busy_r) begin
        rem_r  <= qbit ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
        quo_r  <= {quo_r[DIV_W-2:0], qbit};
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done   = done_r;
  assign res.rem_nz = |rem_r;
  assign res.quo    = quo_r;
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lbp_pkg::*;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [1:0]  st;
    logic        last;
  } bound_beat_t;

  typedef struct {
    shortint     coef;
    int          lo;
    int          hi;
    bit          last;
    bit          typed;
    bound_beat_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_RHS;
  logic [RHS_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [79:0]           in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [71:0]           out_tdata;
  logic [ST_W-1:0]       out_tuser;
  logic                  out_tlast;

  bound_beat_t bounds_q[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  // predictor state
  longint k_mem[MAX_TERMS];
  longint lo_mem[MAX_TERMS];
  longint hi_mem[MAX_TERMS];
  int     n_terms = 0;
  longint rhs = 0;
  bit     eq_mode = 1'b0;

  linear_bounds_propagator_core u_top (.*);

  always #6 clk = ~clk;

  function automatic longint least(longint k, longint lo, longint hi);
    return (k >= 0) ? k * lo : k * hi;
  endfunction

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic longint cdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) == (b < 0))) q++;
    return q;
  endfunction

  // one pass; returns failing term or -1
  function automatic int tighten_pass(longint sgn, longint bound, ref bit moved[MAX_TERMS]);
    longint sum, k, without, r, q;
    sum = 0;
    for (int p = 0; p < n_terms; p++) sum += least(sgn * k_mem[p], lo_mem[p], hi_mem[p]);
    for (int p = 0; p < n_terms; p++) begin
      k = sgn * k_mem[p];
      without = sum - least(k, lo_mem[p], hi_mem[p]);
      r = bound - without;
      if (k > 0) begin
        q = fdiv(r, k);
        if (hi_mem[p] > q) begin
          if (q < lo_mem[p]) return p;
          hi_mem[p] = q;
          moved[p] = 1'b1;
        end
      end else begin
        q = cdiv(r, k);
        if (lo_mem[p] < q) begin
          if (q > hi_mem[p]) return p;
          lo_mem[p] = q;
          moved[p] = 1'b1;
        end
      end
      sum = without + least(k, lo_mem[p], hi_mem[p]);
    end
    return -1;
  endfunction

  task automatic propagate_term(shortint c, int lo, int hi, bit last, ref bound_beat_t res[$]);
    bit moved[MAX_TERMS];
    int bad;
    res = {};
    if (n_terms >= MAX_TERMS) n_terms = 0;
    k_mem[n_terms] = c;
    lo_mem[n_terms] = lo;
    hi_mem[n_terms] = hi;
    n_terms++;
    if (!last && n_terms < MAX_TERMS) return;
    for (int i = 0; i < n_terms; i++) begin
      moved[i] = 1'b0;
      if (k_mem[i] == 0 && res.size() == 0)
        res.insert(res.size(), {6'(i), 32'd0, 32'd0, ST_ZERO, 1'b1});
    end
    if (res.size() == 0) begin
      bad = tighten_pass(1, rhs, moved);
      if (bad < 0 && eq_mode) bad = tighten_pass(-1, -rhs, moved);
      if (bad >= 0) res.insert(res.size(), {6'(bad), 32'd0, 32'd0, ST_CONTRA, 1'b1});
      else
        for (int i = 0; i < n_terms; i++)
          res.insert(res.size(), {6'(i), 32'(lo_mem[i]), 32'(hi_mem[i]),
                                  moved[i] ? ST_TIGHT : ST_UNCH, (i == n_terms - 1)});
    end
    n_terms = 0;
  endtask

  task automatic write_reg(logic idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= RHS_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RHS) rhs = val;
    else eq_mode = val[0];
  endtask

  task automatic send_term(shortint c, int lo, int hi, bit last, bit typed = 0,
                           bound_beat_t want = '0);
    bound_beat_t res[$];
    in_tvalid <= 1'b1;
    in_tdata <= {hi, lo, c};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    propagate_term(c, lo, hi, last, res);
    if (typed) res = {want};
    bounds_q = {bounds_q, res};
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    @(posedge clk);
    in_tvalid <= 1'b0;
    wait (bounds_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_term(output shortint c, output int lo, output int hi);
    int pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) c = 0;
    else if (pick < 4) c = (pick == 1) ? -32768 : (pick == 2) ? 32767 : -32767;
    else begin
      c = $urandom_range(1, 9);
      if ($urandom_range(0, 1)) c = -c;
    end
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      lo = $urandom;
      hi = $urandom;
    end else if (pick == 2) begin
      hi = $urandom_range(0, 200) - 100;
      lo = hi + $urandom_range(1, 50);
    end else begin
      lo = $urandom_range(0, 200) - 100;
      hi = lo + $urandom_range(0, 150);
    end
  endtask

  task automatic random_phase(int n_items);
    int sent, len;
    shortint c;
    int lo, hi;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 14) == 0) ? MAX_TERMS : $urandom_range(1, 6);
      for (int t = 0; t < len; t++) begin
        random_term(c, lo, hi);
        send_term(c, lo, hi, (len != MAX_TERMS) && (t == len - 1));
      end
      sent += len;
    end
    settle();
  endtask

  // result checker
  always @(posedge clk) begin
    bound_beat_t want;
    bound_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[5:0], out_tdata[37:6], out_tdata[69:38], out_tuser, out_tlast};
      if (bounds_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat idx=%0d st=%0d", got.idx, got.st);
      end else begin
        want = bounds_q.pop_front();
        if (got !== want || out_tdata[71:70] !== 2'b0) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp idx=%0d lo=%0d hi=%0d st=%0d last=%0b, ",
                      "got idx=%0d lo=%0d hi=%0d st=%0d last=%0b"},
                     want.idx, $signed(want.lo), $signed(want.hi), want.st, want.last,
                     got.idx, $signed(got.lo), $signed(got.hi), got.st, got.last);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #6ms;
    $display("linear_bounds_propagator_core regression: fail");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    rows = '{
      '{0, 5, 9, 1, 1, '{6'd0, 32'd0, 32'd0, ST_ZERO, 1'b1}},
      '{1, 5, 10, 1, 1, '{6'd0, 32'd0, 32'd0, ST_CONTRA, 1'b1}},
      '{1, -10, -5, 1, 1, '{6'd0, -32'sd10, -32'sd5, ST_UNCH, 1'b1}},
      '{1, -10, 10, 1, 0, '0},
      '{-1, -10, 10, 1, 0, '0},
      '{32767, -2147483648, 2147483647, 1, 0, '0},
      '{-32768, -2147483648, 2147483647, 1, 0, '0},
      '{-32768, 2147483647, -2147483648, 1, 0, '0},
      '{2, 10, 3, 1, 0, '0},
      '{3, 0, 7, 0, 0, '0},
      '{0, 1, 2, 0, 0, '0},
      '{-2, -4, 4, 1, 1, '{6'd1, 32'd0, 32'd0, ST_ZERO, 1'b1}},
      '{1, 0, 100, 0, 0, '0},
      '{2, -50, 50, 0, 0, '0},
      '{-3, -20, 20, 1, 0, '0},
      '{5, -1, 1, 0, 0, '0},
      '{-7, -3, 3, 1, 0, '0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    foreach (rows[i]) send_term(rows[i].coef, rows[i].lo, rows[i].hi, rows[i].last,
                                rows[i].typed, rows[i].want);
    settle();
    write_reg(REG_EQ, 1);
    for (int i = 12; i < rows.size(); i++) send_term(rows[i].coef, rows[i].lo, rows[i].hi,
                                                     rows[i].last);
    settle();
    write_reg(REG_RHS, longint'($urandom_range(0, 600)) - 300);
    write_reg(REG_EQ, 0);
    hold_req = 1'b1;
    random_phase(70);
    write_reg(REG_RHS, longint'($urandom_range(0, 600)) - 300);
    write_reg(REG_EQ, 1);
    random_phase(70);
    write_reg(REG_RHS, -(64'sd1 <<< 47));
    write_reg(REG_EQ, 0);
    random_phase(60);
    write_reg(REG_RHS, (64'sd1 <<< 47) - 1);
    write_reg(REG_EQ, 1);
    random_phase(60);
    write_reg(REG_RHS, -(64'sd1 <<< 47));
    random_phase(60);
    write_reg(REG_RHS, longint'($urandom_range(0, 600)) - 300);
    quiet = 1'b1;
    random_phase(70);
    if (errors == 0) $display("linear_bounds_propagator_core regression: pass");
    else $display("linear_bounds_propagator_core regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
src/lbp_pkg.sv
src/lbp_term_ram.sv
src/lbp_div.sv
src/linear_bounds_propagator_core.sv
dv/tb.sv
